>>> rtl/core/nearest_centroid_labeller_top_assert.svh
// Assertion macros for the nearest-centroid labeller top level.
// Plain macros; no dependencies.
`ifndef NEAREST_CENTROID_LABELLER_TOP_ASSERT_SVH
`define NEAREST_CENTROID_LABELLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NCL_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("ncl check failed");
`define NCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("ncl check failed");
`else
`define NCL_ASSERT_IMPL(label, clk, rst_n, prop)
`define NCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/ncl_pkg.sv
// Shared types and constants for the nearest-centroid labeller.
// No dependencies.
package ncl_pkg;
	localparam int MAX_GROUPS  = 4;
	localparam int MAX_CENTERS = 16;
	localparam int MAX_DIMS    = 16;
	localparam int COORD_BITS  = 16;
	localparam int NCELLS      = MAX_GROUPS * MAX_CENTERS;
	localparam int ACC_BITS    = 36;
	localparam int TOT_BITS    = ACC_BITS + $clog2(MAX_CENTERS + 1);
	localparam int CIDX_BITS   = $clog2(NCELLS);
	localparam int DIDX_BITS   = $clog2(MAX_DIMS);
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	localparam logic [1:0] REG_GROUPS  = 2'd0;
	localparam logic [1:0] REG_CENTERS = 2'd1;
	localparam logic [1:0] REG_DIMS    = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [1:0]         group_index;
		logic [3:0]         center_index;
		logic [3:0]         coord_index;
		logic signed [15:0] value;
		logic               last_coord;
	} in_item_t;

	typedef struct packed {
		logic [1:0] group_label;
		logic [3:0] center_label;
	} out_item_t;

	// control broadcast from sequencer to every cell
	typedef struct packed {
		logic                   load;     // write center coordinate
		logic [CIDX_BITS-1:0]   load_cell;
		logic                   acc;      // accumulate point coordinate
		logic [DIDX_BITS-1:0]   dim;
		logic                   clear;    // clear accumulators
		logic                   shift;    // shift accumulators toward cell 0
	} cell_ctl_t;
endpackage

>>> rtl/core/nearest_centroid_labeller_top.sv
// Top level: config registers, sequencer, chain of center cells, selector.
// Depends on ncl_pkg, ncl_cell, ncl_select, nearest_centroid_labeller_top_assert.svh.
//  channel | dir | handshake      | payload
//  in      | in  | valid/ready    | in_item_t
//  out     | out | out_valid/rdy  | out_item_t
//  cfg     | in  | cfg_valid/rdy  | cfg_index, cfg_data
// A load or a point coordinate without last passes ST_IDLE (read), then ST_ACC
// (accumulate). A last coordinate then shifts all 64 cells toward cell 0, one cell
// per cycle, while the serial argmin at the chain end takes the cells in use; then
// ST_WAIT waits for the argmin and ST_OUT holds the label until out_ready. Input
// and config stall outside ST_IDLE, after a last coordinate until the label leaves.
// Reset clears control and accumulators; center memory is undefined until written.
`include "nearest_centroid_labeller_top_assert.svh"
module nearest_centroid_labeller_top import ncl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ACC   = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0] groups_q;
	logic [4:0] centers_q, dims_q;
	logic       last_q;
	logic [DIDX_BITS-1:0] dim_q;
	logic [6:0] shift_cnt_q;
	cell_ctl_t ctl;
	logic [ACC_BITS-1:0] link [NCELLS+1];
	logic sel_done, sel_start, sel_step;
	out_item_t sel_res;
	logic in_fire;

	function automatic logic [4:0] clamp(input logic [4:0] v, input logic [4:0] mx);
		logic [4:0] r;
		r = (v == 5'd0) ? 5'd1 : ((v > mx) ? mx : v);
		return r;
	endfunction

	assign cfg_ready = state_q == ST_IDLE;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= 3'd1; centers_q <= 5'd1; dims_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GROUPS:  groups_q  <= 3'(clamp({2'b0, cfg_data[2:0]}, 5'(MAX_GROUPS)));
				REG_CENTERS: centers_q <= clamp(cfg_data, 5'(MAX_CENTERS));
				REG_DIMS:    dims_q    <= clamp(cfg_data, 5'(MAX_DIMS));
				default: ;
			endcase
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		ctl = '0;
		ctl.dim       = in_fire ? in_data.coord_index : dim_q;
		ctl.load      = in_fire && in_data.opcode == OP_LOAD;
		ctl.load_cell = {in_data.group_index, in_data.center_index};
		ctl.acc       = in_fire && in_data.opcode == OP_POINT
			&& 5'(in_data.coord_index) < dims_q;
		ctl.shift     = state_q == ST_SHIFT;
		ctl.clear     = state_q == ST_OUT && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; last_q <= 1'b0; dim_q <= '0; shift_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					dim_q  <= in_data.coord_index;
					last_q <= in_data.opcode == OP_POINT && in_data.last_coord;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					shift_cnt_q <= '0;
					state_q <= last_q ? ST_SHIFT : ST_IDLE;
				end
				ST_SHIFT: begin
					shift_cnt_q <= shift_cnt_q + 7'd1;
					if (shift_cnt_q == 7'(NCELLS - 1))
						state_q <= ST_WAIT;
				end
				ST_WAIT: if (sel_done) state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign link[NCELLS] = '0;
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		ncl_cell u_cell (
			.clk, .arst_n, .ctl,
			.my_index (CIDX_BITS'(i)),
			.in_use   (3'(i / MAX_CENTERS) < groups_q && 5'(i % MAX_CENTERS) < centers_q),
			.value    (in_data.value),
			.acc_in   (link[i+1]),
			.acc_out  (link[i])
		);
	end

	// cell 0 shows cell k at shift k; keep only centers in use of groups in use
	assign sel_start = state_q == ST_ACC;
	assign sel_step  = state_q == ST_SHIFT && 5'(shift_cnt_q[3:0]) < centers_q
		&& 3'(shift_cnt_q[5:4]) < groups_q;

	ncl_select u_sel (
		.clk, .arst_n,
		.start (sel_start),
		.step  (sel_step),
		.acc   (link[0]),
		.groups (groups_q),
		.centers (centers_q),
		.done  (sel_done),
		.result (sel_res)
	);

	assign out_valid = state_q == ST_OUT;
	assign out_data  = sel_res;

	`NCL_ASSERT_IMPL(a_out_not_in, clk, arst_n, !(out_valid && in_ready))
	`NCL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`NCL_ASSERT_NEXT(a_done_out, clk, arst_n, sel_done && state_q == ST_WAIT, out_valid)
endmodule

>>> rtl/core/ncl_cell.sv
// One center cell: coordinate memory, squared-distance accumulator, shift link.
// Depends on ncl_pkg.
module ncl_cell import ncl_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic [CIDX_BITS-1:0]         my_index,
	input  logic                         in_use,
	input  logic signed [COORD_BITS-1:0] value,
	input  logic [ACC_BITS-1:0]          acc_in,
	output logic [ACC_BITS-1:0]          acc_out
);
	logic signed [COORD_BITS-1:0] mem_q [MAX_DIMS];
	logic signed [COORD_BITS-1:0] cv_q;
	logic signed [COORD_BITS-1:0] pv_q;
	logic                         acc_s1;
	logic signed [COORD_BITS:0]   diff;
	logic [2*COORD_BITS+1:0]      sq;
	logic [ACC_BITS:0]            sum;
	logic [ACC_BITS-1:0]          acc_q;

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.load_cell == my_index)
			mem_q[ctl.dim] <= value;
		cv_q <= mem_q[ctl.dim];
		pv_q <= value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_s1 <= 1'b0;
		else
			acc_s1 <= ctl.acc && in_use;
	end

	always_comb begin
		diff = {pv_q[COORD_BITS-1], pv_q} - {cv_q[COORD_BITS-1], cv_q};
		sq = (2*COORD_BITS+2)'(diff * diff);
		sum = {1'b0, acc_q} + (ACC_BITS+1)'(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (ctl.clear)
			acc_q <= '0;
		else if (ctl.shift)
			acc_q <= acc_in;
		else if (acc_s1)
			acc_q <= sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
	end

	assign acc_out = acc_q;
endmodule

>>> rtl/core/ncl_select.sv
// Serial argmin over the accumulator stream leaving cell 0: group totals, then centers.
// Depends on ncl_pkg.
module ncl_select import ncl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                step,
	input  logic [ACC_BITS-1:0] acc,
	input  logic [2:0]          groups,
	input  logic [4:0]          centers,
	output logic                done,
	output out_item_t           result
);
	logic [1:0]          g_q;
	logic [3:0]          c_q;
	logic [TOT_BITS-1:0] tot_q, best_tot_q;
	logic [1:0]          best_g_q;
	logic [ACC_BITS-1:0] cbest_q [MAX_GROUPS];
	logic [3:0]          cidx_q [MAX_GROUPS];
	logic [TOT_BITS-1:0] tot_n;
	logic                last_c, last_g;

	assign tot_n  = tot_q + TOT_BITS'(acc);
	assign last_c = (5'(c_q) + 5'd1) == centers;
	assign last_g = (3'(g_q) + 3'd1) == groups;

	// done stays high from the last step until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= '0; c_q <= '0; tot_q <= '0; best_tot_q <= '0; best_g_q <= '0;
			done <= 1'b0;
		end else if (start) begin
			g_q <= '0; c_q <= '0; tot_q <= '0;
			done <= 1'b0;
		end else if (step) begin
			if (last_c) begin
				c_q   <= '0;
				tot_q <= '0;
				g_q   <= g_q + 2'd1;
				if (g_q == 2'd0 || tot_n < best_tot_q) begin
					best_tot_q <= tot_n;
					best_g_q   <= g_q;
				end
				if (last_g)
					done <= 1'b1;
			end else begin
				c_q   <= c_q + 4'd1;
				tot_q <= tot_n;
			end
		end
	end

	// per-group best center, written on the first center of each group before any read
	always_ff @(posedge clk) begin
		if (step && (c_q == 4'd0 || acc < cbest_q[g_q])) begin
			cbest_q[g_q] <= acc;
			cidx_q[g_q]  <= c_q;
		end
	end

	assign result.group_label  = best_g_q;
	assign result.center_label = cidx_q[best_g_q];
endmodule

>>> sim/tb.sv
// Testbench for nearest_centroid_labeller_top: directed table, then random phases.
// Labels come from typed table rows, else from a model kept in step with accepted beats.
// Depends on ncl_pkg and the RTL of the labeller.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ncl_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE = 120;
	localparam int PHASE_ITEMS = 32;

	typedef enum logic [1:0] {VAL_ANY, VAL_EDGE, VAL_TINY} val_mode_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [4:0]  data;
		in_item_t    it;
		bit          typed;
		out_item_t   lbl;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	nearest_centroid_labeller_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// labeller model state
	logic signed [15:0] ctr_mem [MAX_GROUPS*MAX_CENTERS*MAX_DIMS];
	bit                 ctr_seen [MAX_GROUPS*MAX_CENTERS*MAX_DIMS];
	logic [35:0]        dist_acc [NCELLS];
	int unsigned        n_groups, n_centers, n_dims;

	out_item_t label_q[$];
	int errors;
	int sent;
	bit hold_req, fast_mode;

	function automatic int unsigned clamp_count(logic [4:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic logic [35:0] acc_sq(logic [35:0] acc, longint diff);
		longint unsigned mag, sq;
		mag = diff < 0 ? -diff : diff;
		if (mag >= (64'd1 << 18))
			return ACC_MAX;
		sq = mag * mag;
		if (sq > 64'(ACC_MAX) - 64'(acc))
			return ACC_MAX;
		return 36'(64'(acc) + sq);
	endfunction

	task automatic model_cfg(logic [1:0] idx, logic [4:0] data);
		case (idx)
			REG_GROUPS: n_groups = clamp_count({2'b0, data[2:0]}, MAX_GROUPS);
			REG_CENTERS: n_centers = clamp_count(data, MAX_CENTERS);
			REG_DIMS: n_dims = clamp_count(data, MAX_DIMS);
			default: ;
		endcase
	endtask

	task automatic label_point(in_item_t it, output bit has, output out_item_t res);
		int unsigned a, bg, bc;
		longint unsigned tot, best;
		has = 0;
		res = '0;
		if (it.opcode == OP_LOAD) begin
			ctr_mem[(it.group_index*MAX_CENTERS + it.center_index)*MAX_DIMS + it.coord_index]
				= it.value;
			ctr_seen[(it.group_index*MAX_CENTERS + it.center_index)*MAX_DIMS + it.coord_index]
				= 1;
			return;
		end
		if (it.coord_index < n_dims)
			for (int g = 0; g < n_groups; g++)
				for (int c = 0; c < n_centers; c++) begin
					a = g*MAX_CENTERS + c;
					dist_acc[a] = acc_sq(dist_acc[a],
						longint'(it.value) - longint'(ctr_mem[a*MAX_DIMS + it.coord_index]));
				end
		if (!it.last_coord)
			return;
		bg = 0;
		best = 0;
		for (int g = 0; g < n_groups; g++) begin
			tot = 0;
			for (int c = 0; c < n_centers; c++)
				tot += dist_acc[g*MAX_CENTERS + c];
			if (g == 0 || tot < best) begin
				best = tot;
				bg = g;
			end
		end
		bc = 0;
		for (int c = 1; c < n_centers; c++)
			if (dist_acc[bg*MAX_CENTERS + c] < dist_acc[bg*MAX_CENTERS + bc])
				bc = c;
		foreach (dist_acc[i])
			dist_acc[i] = '0;
		has = 1;
		res.group_label = bg[1:0];
		res.center_label = bc[3:0];
	endtask

	function automatic logic signed [15:0] rand_val(val_mode_t m);
		case (m)
			VAL_EDGE: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			VAL_TINY: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		in_valid <= 0;
		in_data <= '0;
		out_ready <= 0;
		cfg_valid <= 0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// result sink with random and long stalls
	initial begin
		int n;
		out_item_t want;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (400) @(posedge clk);
			end else begin
				n = fast_mode ? 0 : $urandom_range(0, 13);
				if (n != 0) begin
					out_ready <= 0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			if (label_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat %p", $time, out_data);
			end else begin
				want = label_q.pop_front();
				if (out_data.group_label !== want.group_label) begin
					errors++;
					$display("%0t: group_label expected %0d actual %0d", $time,
						want.group_label, out_data.group_label);
				end
				if (out_data.center_label !== want.center_label) begin
					errors++;
					$display("%0t: center_label expected %0d actual %0d", $time,
						want.center_label, out_data.center_label);
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else if (arst_n && ++idle >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_item(in_item_t it, bit typed, out_item_t lbl);
		int gap;
		bit has;
		out_item_t res;
		gap = fast_mode ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
		label_point(it, has, res);
		if (has)
			label_q.push_back(typed ? lbl : res);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		model_cfg(idx, data);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (label_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// point coordinate; centers it would read are loaded first
	task automatic send_coord(logic [3:0] d, logic signed [15:0] v, bit last, val_mode_t m);
		in_item_t it;
		int a;
		if (d < n_dims)
			for (int g = 0; g < n_groups; g++)
				for (int c = 0; c < n_centers; c++) begin
					a = (g*MAX_CENTERS + c)*MAX_DIMS + d;
					if (!ctr_seen[a]) begin
						it = '{OP_LOAD, 2'(g), 4'(c), d, rand_val(m), 1'($urandom)};
						send_item(it, 0, '0);
					end
				end
		it = '{OP_POINT, 2'($urandom), 4'($urandom), d, v, last};
		send_item(it, 0, '0);
	endtask

	function automatic row_t row_ld(int g, int c, int d, logic signed [15:0] v, bit last);
		row_t r;
		r = '{0, 2'd0, 5'd0, '{OP_LOAD, 2'(g), 4'(c), 4'(d), v, last}, 0, '0};
		return r;
	endfunction

	function automatic row_t row_pt(int d, logic signed [15:0] v, bit last, bit typed,
		int gl, int cl);
		row_t r;
		r = '{0, 2'd0, 5'd0, '{OP_POINT, 2'd3, 4'd15, 4'(d), v, last}, typed,
			'{2'(gl), 4'(cl)}};
		return r;
	endfunction

	function automatic row_t row_cfg(logic [1:0] idx, int data);
		row_t r;
		r = '{1, idx, 5'(data), '0, 0, '0};
		return r;
	endfunction

	initial begin
		row_t rows[$];
		int set_g[10], set_c[10], set_d[10];
		int len, cnt;
		val_mode_t m;
		logic [3:0] d;
		errors = 0;
		sent = 0;
		hold_req = 0;
		fast_mode = 0;
		n_groups = 1;
		n_centers = 1;
		n_dims = 1;
		foreach (dist_acc[i])
			dist_acc[i] = '0;
		foreach (ctr_seen[i])
			ctr_seen[i] = 0;

		// reset config: one group, one center, one dim
		rows.push_back(row_ld(0, 0, 0, 16'sh7fff, 0));
		rows.push_back(row_pt(0, 16'sh8000, 1, 1, 0, 0));
		rows.push_back(row_ld(3, 15, 15, 16'sh8000, 1));   // last flag on load is ignored
		rows.push_back(row_ld(0, 0, 0, 16'sh8000, 0));
		rows.push_back(row_pt(0, 16'sh8000, 1, 1, 0, 0));
		rows.push_back(row_pt(15, 16'sh7fff, 1, 1, 0, 0)); // coord beyond dims still labels
		rows.push_back(row_pt(0, 16'sh0000, 0, 0, 0, 0));
		rows.push_back(row_pt(0, 16'sh0005, 0, 0, 0, 0));  // repeated coord adds again
		rows.push_back(row_pt(0, -16'sd1, 1, 1, 0, 0));
		rows.push_back(row_cfg(REG_GROUPS, 2));
		rows.push_back(row_cfg(REG_CENTERS, 2));
		rows.push_back(row_cfg(REG_SPARE, 31));
		rows.push_back(row_ld(0, 1, 0, 16'sd100, 0));
		rows.push_back(row_ld(1, 0, 0, -16'sd100, 0));
		rows.push_back(row_ld(1, 1, 0, 16'sd50, 0));
		rows.push_back(row_pt(0, 16'sd100, 1, 0, 0, 0));
		rows.push_back(row_pt(0, 16'sd50, 1, 0, 0, 0));
		rows.push_back(row_ld(1, 1, 0, -16'sd100, 0));
		rows.push_back(row_pt(0, -16'sd100, 1, 0, 0, 0)); // tie inside group 1
		rows.push_back(row_ld(0, 0, 0, 16'sd7, 0));
		rows.push_back(row_ld(0, 1, 0, 16'sd7, 0));
		rows.push_back(row_ld(1, 0, 0, 16'sd7, 0));
		rows.push_back(row_ld(1, 1, 0, 16'sd7, 0));
		rows.push_back(row_pt(0, 16'sd7, 1, 1, 0, 0));    // all tied: lowest indices

		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_reg(rows[i].idx, rows[i].data);
			end else
				send_item(rows[i].it, rows[i].typed, rows[i].lbl);
		end

		set_g = '{1, 0, 2, 4, 7, 3, 4, 1, 0, 0};
		set_c = '{1, 0, 3, 16, 31, 16, 1, 16, 0, 0};
		set_d = '{1, 0, 4, 16, 31, 2, 16, 1, 0, 0};
		for (int p = 0; p < 10; p++) begin
			drain();
			if (p >= 8) begin
				set_g[p] = $urandom_range(0, 7);
				set_c[p] = $urandom_range(0, 31);
				set_d[p] = $urandom_range(0, 31);
			end
			write_reg(REG_DIMS, 5'(set_d[p]));
			write_reg(REG_CENTERS, 5'(set_c[p]));
			write_reg(REG_GROUPS, 5'(set_g[p]));
			fast_mode = (p % 3 == 1);
			if (p == 2)
				hold_req = 1;
			// budget counts every beat, center loads included
			cnt = sent;
			while (sent - cnt < PHASE_ITEMS) begin
				m = val_mode_t'($urandom_range(0, 2));
				if ($urandom_range(0, 6) == 0) begin
					send_item('{OP_LOAD, 2'($urandom), 4'($urandom), 4'($urandom),
						rand_val(m), 1'($urandom)}, 0, '0);
				end else begin
					len = $urandom_range(1, (m == VAL_EDGE) ? 20 : n_dims + 2);
					for (int k = 0; k < len; k++) begin
						d = ($urandom_range(0, 7) == 0) ? 4'($urandom) :
							4'($urandom_range(0, n_dims - 1));
						send_coord(d, rand_val(m), k == len - 1, m);
					end
				end
			end
		end

		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
